// ----- hw/rtl/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvt_pkg
// shared types and codes for the key/value table and its slot cells
// ----------------------------------------------------------------------------
package kvt_pkg;

    // request commands; code 3 is unused and answers as a miss
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2
    } kvt_cmd_t;

    // result status codes
    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_REMOVED   = 3'd4,
        STAT_FULL      = 3'd5
    } kvt_status_t;

    // slot write operations broadcast to the cells
    typedef enum logic [1:0] {
        WR_FILL   = 2'd0,
        WR_UPDATE = 2'd1,
        WR_CLEAR  = 2'd2
    } kvt_wr_op_t;

    typedef struct packed {
        logic       en;
        kvt_wr_op_t op;
    } kvt_wr_t;

    // flags carried by the probe as it walks the chain
    typedef struct packed {
        logic valid;
        logic hit;
        logic free_found;
    } kvt_probe_t;

    // control states of the top level
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LAUNCH = 2'd1,
        S_SCAN   = 2'd2,
        S_COMMIT = 2'd3
    } kvt_state_t;

endpackage

// ----- hw/rtl/kvt_cell.sv -----
// ----------------------------------------------------------------------------
// kvt_cell
// one table slot: stores key, value and valid bit, and passes the probe on
// ----------------------------------------------------------------------------
module kvt_cell #(
    parameter int CELL_ID    = 0,
    parameter int IDX_W      = 4,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [KEY_BITS-1:0]   req_key,
    input  kvt_pkg::kvt_wr_t      wr_cmd,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [VALUE_BITS-1:0] wr_value,
    input  kvt_pkg::kvt_probe_t   probe_in,
    input  logic [IDX_W-1:0]      hit_idx_in,
    input  logic [IDX_W-1:0]      free_idx_in,
    input  logic [VALUE_BITS-1:0] hit_value_in,
    output kvt_pkg::kvt_probe_t   probe_out,
    output logic [IDX_W-1:0]      hit_idx_out,
    output logic [IDX_W-1:0]      free_idx_out,
    output logic [VALUE_BITS-1:0] hit_value_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    logic                  slot_valid_reg, slot_valid_next;
    logic [KEY_BITS-1:0]   slot_key_reg, slot_key_next;
    logic [VALUE_BITS-1:0] slot_value_reg, slot_value_next;

    kvt_pkg::kvt_probe_t   probe_reg, probe_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [VALUE_BITS-1:0] hit_value_reg, hit_value_next;

    logic match;
    logic selected;

    assign match    = slot_valid_reg && (slot_key_reg == req_key);
    assign selected = wr_cmd.en && (wr_idx == MY_IDX);

    // slot update from the commit broadcast
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        slot_key_next   = slot_key_reg;
        slot_value_next = slot_value_reg;
        if (selected)
        begin
            case (wr_cmd.op)
                kvt_pkg::WR_FILL:
                begin
                    slot_valid_next = 1'b1;
                    slot_key_next   = req_key;
                    slot_value_next = wr_value;
                end
                kvt_pkg::WR_UPDATE:
                begin
                    slot_value_next = wr_value;
                end
                kvt_pkg::WR_CLEAR:
                begin
                    slot_valid_next = 1'b0;
                end
                default:
                begin
                    slot_valid_next = slot_valid_reg;
                end
            endcase
        end
    end

    // probe stage: first match and lowest free slot
    always_comb
    begin
        probe_next     = probe_in;
        hit_idx_next   = hit_idx_in;
        free_idx_next  = free_idx_in;
        hit_value_next = hit_value_in;
        if (probe_in.valid && !probe_in.hit && match)
        begin
            probe_next.hit = 1'b1;
            hit_idx_next   = MY_IDX;
            hit_value_next = slot_value_reg;
        end
        if (probe_in.valid && !probe_in.free_found && !slot_valid_reg)
        begin
            probe_next.free_found = 1'b1;
            free_idx_next         = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            probe_reg      <= '0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            probe_reg      <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_key_reg   <= slot_key_next;
        slot_value_reg <= slot_value_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        hit_value_reg  <= hit_value_next;
    end

    assign probe_out     = probe_reg;
    assign hit_idx_out   = hit_idx_reg;
    assign free_idx_out  = free_idx_reg;
    assign hit_value_out = hit_value_reg;

endmodule

// ----- hw/rtl/key_value_table.sv -----
// ----------------------------------------------------------------------------
// key_value_table
// bounded store of unique keys with insert, lookup and remove
// ----------------------------------------------------------------------------
// The table is a row of ENTRIES slot cells. An accepted item sends a probe
// down the row, one cell per cycle; each cell notes a key match and the
// lowest free slot. At the tail the outcome is decided and at most one write
// (fill, update or clear) is broadcast to the addressed cell, and one result
// item is produced with the entry count after the request. One item is in
// work at a time; the next item is accepted once the result of the last is
// committed. A finished result sits in an output register, so the next item
// can be taken while it waits. A new key goes into the lowest free slot; when
// all slots are full a new key is refused with the full status, while an
// update of a present key still succeeds. Command code 3 changes nothing and
// answers not found. found_value is zero unless the status is found, and
// entry_count is the entry count taken modulo 32.
module key_value_table #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] key,
    input  logic [31:0] value,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] found_value,
    output logic [4:0]  entry_count
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // control state
    kvt_pkg::kvt_state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    // request held for the whole walk
    logic [1:0]            req_cmd_reg, req_cmd_next;
    logic [KEY_BITS-1:0]   req_key_reg, req_key_next;
    logic [VALUE_BITS-1:0] req_value_reg, req_value_next;

    // probe outcome captured at the tail of the row
    logic                  res_hit_reg, res_hit_next;
    logic                  res_free_reg, res_free_next;
    logic [IDX_W-1:0]      res_hit_idx_reg, res_hit_idx_next;
    logic [IDX_W-1:0]      res_free_idx_reg, res_free_idx_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] found_value_reg, found_value_next;
    logic [4:0]  entry_count_reg, entry_count_next;

    // commit broadcast
    kvt_pkg::kvt_wr_t wr_cmd;
    logic [IDX_W-1:0] wr_idx;

    // probe chain between the cells
    kvt_pkg::kvt_probe_t   chain_flags     [ENTRIES+1];
    logic [IDX_W-1:0]      chain_hit_idx   [ENTRIES+1];
    logic [IDX_W-1:0]      chain_free_idx  [ENTRIES+1];
    logic [VALUE_BITS-1:0] chain_hit_value [ENTRIES+1];

    // port widths vs parameter widths
    logic [KEY_BITS+31:0]   key_wide;
    logic [VALUE_BITS+31:0] value_wide;
    logic [VALUE_BITS+31:0] found_wide;
    logic [CNT_W+4:0]       count_wide;
    logic                   out_free;

    assign key_wide   = (KEY_BITS + 32)'(key);
    assign value_wide = (VALUE_BITS + 32)'(value);
    assign found_wide = (VALUE_BITS + 32)'(res_value_reg);
    assign out_free   = !out_valid_reg || out_ready;

    // head of the row: a fresh probe in the launch cycle
    always_comb
    begin
        chain_flags[0]       = '0;
        chain_flags[0].valid = (state_reg == kvt_pkg::S_LAUNCH);
        chain_hit_idx[0]     = '0;
        chain_free_idx[0]    = '0;
        chain_hit_value[0]   = '0;
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kvt_cell #(
            .CELL_ID    (i),
            .IDX_W      (IDX_W),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .req_key       (req_key_reg),
            .wr_cmd        (wr_cmd),
            .wr_idx        (wr_idx),
            .wr_value      (req_value_reg),
            .probe_in      (chain_flags[i]),
            .hit_idx_in    (chain_hit_idx[i]),
            .free_idx_in   (chain_free_idx[i]),
            .hit_value_in  (chain_hit_value[i]),
            .probe_out     (chain_flags[i+1]),
            .hit_idx_out   (chain_hit_idx[i+1]),
            .free_idx_out  (chain_free_idx[i+1]),
            .hit_value_out (chain_hit_value[i+1])
        );
    end

    // next state, commit decision and result
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        req_cmd_next      = req_cmd_reg;
        req_key_next      = req_key_reg;
        req_value_next    = req_value_reg;
        res_hit_next      = res_hit_reg;
        res_free_next     = res_free_reg;
        res_hit_idx_next  = res_hit_idx_reg;
        res_free_idx_next = res_free_idx_reg;
        res_value_next    = res_value_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        status_next       = status_reg;
        found_value_next  = found_value_reg;
        entry_count_next  = entry_count_reg;
        wr_cmd.en         = 1'b0;
        wr_cmd.op         = kvt_pkg::WR_UPDATE;
        wr_idx            = res_hit_idx_reg;
        in_ready          = 1'b0;
        count_wide        = '0;

        case (state_reg)
            kvt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_cmd_next   = command;
                    req_key_next   = key_wide[KEY_BITS-1:0];
                    req_value_next = value_wide[VALUE_BITS-1:0];
                    state_next     = kvt_pkg::S_LAUNCH;
                end
            end
            kvt_pkg::S_LAUNCH:
            begin
                state_next = kvt_pkg::S_SCAN;
            end
            kvt_pkg::S_SCAN:
            begin
                // probe leaves the last cell
                if (chain_flags[ENTRIES].valid)
                begin
                    res_hit_next      = chain_flags[ENTRIES].hit;
                    res_free_next     = chain_flags[ENTRIES].free_found;
                    res_hit_idx_next  = chain_hit_idx[ENTRIES];
                    res_free_idx_next = chain_free_idx[ENTRIES];
                    res_value_next    = chain_hit_value[ENTRIES];
                    state_next        = kvt_pkg::S_COMMIT;
                end
            end
            kvt_pkg::S_COMMIT:
            begin
                // write the slot and hand off the result together
                if (out_free)
                begin
                    status_next      = kvt_pkg::STAT_NOT_FOUND;
                    found_value_next = '0;
                    case (req_cmd_reg)
                        kvt_pkg::CMD_INSERT:
                        begin
                            if (res_hit_reg)
                            begin
                                wr_cmd.en   = 1'b1;
                                wr_cmd.op   = kvt_pkg::WR_UPDATE;
                                status_next = kvt_pkg::STAT_UPDATED;
                            end
                            else if (res_free_reg)
                            begin
                                wr_cmd.en   = 1'b1;
                                wr_cmd.op   = kvt_pkg::WR_FILL;
                                wr_idx      = res_free_idx_reg;
                                count_next  = count_reg + CNT_W'(1);
                                status_next = kvt_pkg::STAT_INSERTED;
                            end
                            else
                            begin
                                status_next = kvt_pkg::STAT_FULL;
                            end
                        end
                        kvt_pkg::CMD_LOOKUP:
                        begin
                            if (res_hit_reg)
                            begin
                                found_value_next = found_wide[31:0];
                                status_next      = kvt_pkg::STAT_FOUND;
                            end
                        end
                        kvt_pkg::CMD_REMOVE:
                        begin
                            if (res_hit_reg)
                            begin
                                wr_cmd.en   = 1'b1;
                                wr_cmd.op   = kvt_pkg::WR_CLEAR;
                                count_next  = count_reg - CNT_W'(1);
                                status_next = kvt_pkg::STAT_REMOVED;
                            end
                        end
                        default:
                        begin
                            status_next = kvt_pkg::STAT_NOT_FOUND;
                        end
                    endcase
                    count_wide       = (CNT_W + 5)'(count_next);
                    entry_count_next = count_wide[4:0];
                    out_valid_next   = 1'b1;
                    state_next       = kvt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kvt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kvt_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_cmd_reg      <= req_cmd_next;
        req_key_reg      <= req_key_next;
        req_value_reg    <= req_value_next;
        res_hit_reg      <= res_hit_next;
        res_free_reg     <= res_free_next;
        res_hit_idx_reg  <= res_hit_idx_next;
        res_free_idx_reg <= res_free_idx_next;
        res_value_reg    <= res_value_next;
        status_reg       <= status_next;
        found_value_reg  <= found_value_next;
        entry_count_reg  <= entry_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_value_reg;
    assign entry_count = entry_count_reg;

endmodule

// ----- hw/rtl/kvt_checker.sv -----
// ----------------------------------------------------------------------------
// kvt_checker
// port-level checks on the key/value table, bound to the top level
// ----------------------------------------------------------------------------
module kvt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [31:0] found_value,
    input logic [4:0]  entry_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(status) && $stable(found_value) && $stable(entry_count))
        else $error("result changed while stalled");

    // found_value only carries data on a hit
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != kvt_pkg::STAT_FOUND) |-> found_value == 32'd0)
        else $error("found_value nonzero without a hit");

    // one item in work: no acceptance right after an acceptance
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

endmodule

bind key_value_table kvt_checker u_kvt_checker (.*);
